@@ design/cfmq_pkg.sv @@
// Shared types, constants and helper functions for the circular FIFO with membership query.
package cfmq_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CAP_W  = 5;

    typedef logic signed [DATA_W-1:0] word_t;
    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic [CNT_W-1:0]         cnt_t;
    typedef logic [CAP_W-1:0]         cap_t;

    typedef enum logic [1:0] {
        KIND_ENQ   = 2'd0,
        KIND_DEQ   = 2'd1,
        KIND_QUERY = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    // Clamp the programmed capacity into 1..DEPTH.
    function automatic cnt_t eff_cap(input cap_t cap);
        cnt_t result;
        if (cap == '0) begin
            result = cnt_t'(1);
        end else if ({1'b0, cap} > (CAP_W + 1)'(DEPTH)) begin
            result = cnt_t'(DEPTH);
        end else begin
            result = cnt_t'(cap);
        end
        return result;
    endfunction

    // Step an index around the ring, wrapping at the effective capacity.
    function automatic idx_t advance(input idx_t idx, input cnt_t cap);
        logic [IDX_W:0] n;
        n = {1'b0, idx} + (IDX_W + 1)'(1);
        return ((CNT_W + 1)'(n) >= (CNT_W + 1)'(cap)) ? '0 : n[IDX_W-1:0];
    endfunction

endpackage

@@ design/cfmq_ram.sv @@
// Simple dual-port synchronous RAM with one write port and one registered read port.
module cfmq_ram #(
    parameter int DATA_W = 32,
    parameter int ADDR_W = 4
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Hold read data until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/circular_fifo_with_membership_query.sv @@
// Top level: circular FIFO of signed words with a membership query over a RAM-backed ring.
//
// Input channel (in_valid/in_ready, kind, value) takes one operation per transaction:
// enqueue, dequeue or membership query. Output channel (out_valid/out_ready) returns one
// result per operation: status, read_value, found and occupancy after the operation.
// The configuration channel (cfg_valid/cfg_ready, capacity) sets the queue size (clamped
// to 1..16) and empties the queue; it is taken only while no operation is in flight.
// Entries live in a 16-word RAM with a registered read port. Enqueue, no-op and refused
// operations write their result directly from idle; a dequeue waits for its one RAM read;
// a query reads the stored entries one per cycle through the single read port, and on
// an empty queue it reads nothing. One operation is in flight at a time.
// The result sits in an output register, so a new operation is accepted while the
// previous result is being taken. If the receiver stalls, the finished result holds and
// the block waits before starting the next operation.
// Reset empties the queue and sets capacity to 16; RAM contents are left as they are.
module circular_fifo_with_membership_query (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             kind,
    input  logic signed [31:0]     value,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [1:0]             status,
    output logic signed [31:0]     read_value,
    output logic                   found,
    output logic [4:0]             occupancy,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [4:0]             capacity
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DEQ  = 3'b010,
        ST_SCAN = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    cfmq_pkg::cap_t      cap_reg, cap_next;
    cfmq_pkg::idx_t      head_reg, head_next;
    cfmq_pkg::idx_t      tail_reg, tail_next;
    cfmq_pkg::cnt_t      count_reg, count_next;
    cfmq_pkg::idx_t      scan_idx_reg, scan_idx_next;
    cfmq_pkg::cnt_t      scan_left_reg, scan_left_next;
    logic                rd_pending_reg, rd_pending_next;
    logic                hit_reg, hit_next;
    cfmq_pkg::word_t     key_reg, key_next;

    logic                out_valid_reg, out_valid_next;
    cfmq_pkg::status_t   status_reg, status_next;
    cfmq_pkg::word_t     read_value_reg, read_value_next;
    logic                found_reg, found_next;
    cfmq_pkg::cnt_t      occupancy_reg, occupancy_next;

    logic                ram_we;
    cfmq_pkg::idx_t      ram_waddr;
    logic                ram_re;
    cfmq_pkg::idx_t      ram_raddr;
    logic [cfmq_pkg::DATA_W-1:0] ram_rdata;

    cfmq_pkg::cnt_t      cap_eff;
    logic                slot_free;
    logic                in_fire;
    logic                cfg_fire;

    cfmq_ram #(
        .DATA_W (cfmq_pkg::DATA_W),
        .ADDR_W (cfmq_pkg::IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (value),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cap_eff   = cfmq_pkg::eff_cap(cap_reg);
    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE) && slot_free;
    // Hold the configuration write while an operation is taken on the same edge.
    assign cfg_ready = (state_reg == ST_IDLE) && !in_fire;
    assign in_fire   = in_valid && in_ready;
    assign cfg_fire  = cfg_valid && cfg_ready;

    always_comb
    begin
        state_next      = state_reg;
        cap_next        = cap_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        scan_idx_next   = scan_idx_reg;
        scan_left_next  = scan_left_reg;
        rd_pending_next = 1'b0;
        hit_next        = hit_reg;
        key_next        = key_reg;

        out_valid_next  = out_valid_reg && !out_ready;
        status_next     = status_reg;
        read_value_next = read_value_reg;
        found_next      = found_reg;
        occupancy_next  = occupancy_reg;

        ram_we    = 1'b0;
        ram_waddr = tail_reg;
        ram_re    = 1'b0;
        ram_raddr = head_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    status_next     = cfmq_pkg::STATUS_OK;
                    read_value_next = '0;
                    found_next      = 1'b0;
                    occupancy_next  = count_reg;
                    unique case (kind)
                        cfmq_pkg::KIND_ENQ:
                        begin
                            out_valid_next = 1'b1;
                            if (count_reg >= cap_eff)
                            begin
                                status_next = cfmq_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                ram_we         = 1'b1;
                                tail_next      = cfmq_pkg::advance(tail_reg, cap_eff);
                                count_next     = count_reg + cfmq_pkg::cnt_t'(1);
                                occupancy_next = count_reg + cfmq_pkg::cnt_t'(1);
                            end
                        end
                        cfmq_pkg::KIND_DEQ:
                        begin
                            if (count_reg == '0)
                            begin
                                out_valid_next = 1'b1;
                                status_next    = cfmq_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                head_next  = cfmq_pkg::advance(head_reg, cap_eff);
                                count_next = count_reg - cfmq_pkg::cnt_t'(1);
                                state_next = ST_DEQ;
                            end
                        end
                        cfmq_pkg::KIND_QUERY:
                        begin
                            key_next       = value;
                            scan_idx_next  = head_reg;
                            scan_left_next = count_reg;
                            hit_next       = 1'b0;
                            state_next     = ST_SCAN;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
                else if (cfg_fire)
                begin
                    cap_next   = capacity;
                    head_next  = '0;
                    tail_next  = '0;
                    count_next = '0;
                end
            end
            ST_DEQ:
            begin
                // Read data is held by the RAM until the output slot frees up.
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    read_value_next = ram_rdata;
                    occupancy_next  = count_reg;
                    state_next      = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (rd_pending_reg && (cfmq_pkg::word_t'(ram_rdata) == key_reg))
                begin
                    hit_next = 1'b1;
                end
                if (scan_left_reg != '0)
                begin
                    ram_re          = 1'b1;
                    ram_raddr       = scan_idx_reg;
                    rd_pending_next = 1'b1;
                    scan_idx_next   = cfmq_pkg::advance(scan_idx_reg, cap_eff);
                    scan_left_next  = scan_left_reg - cfmq_pkg::cnt_t'(1);
                end
                else if (!rd_pending_reg && slot_free)
                begin
                    out_valid_next = 1'b1;
                    found_next     = hit_reg;
                    occupancy_next = count_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cap_reg        <= cfmq_pkg::cap_t'(cfmq_pkg::DEPTH);
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            scan_left_reg  <= '0;
            rd_pending_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cap_reg        <= cap_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
            scan_left_reg  <= scan_left_next;
            rd_pending_reg <= rd_pending_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_idx_reg   <= scan_idx_next;
        hit_reg        <= hit_next;
        key_reg        <= key_next;
        status_reg     <= status_next;
        read_value_reg <= read_value_next;
        found_reg      <= found_next;
        occupancy_reg  <= occupancy_next;
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign read_value = read_value_reg;
    assign found      = found_reg;
    assign occupancy  = occupancy_reg;

endmodule

@@ verif/circular_fifo_with_membership_query_tb.sv @@
// Self-checking testbench for the circular FIFO with membership query.
`timescale 1ns / 1ps

module circular_fifo_with_membership_query_tb;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam cfmq_pkg::word_t W_MAX = 32'sh7FFF_FFFF;
    localparam cfmq_pkg::word_t W_MIN = 32'sh8000_0000;
    localparam int CYCLE_LIMIT = 400000;
    localparam int IDLE_SETTLE = 40;
    localparam int NUM_PHASES = 8;
    localparam int PHASE_ITEMS = 130;

    typedef struct packed {
        cfmq_pkg::status_t st;
        cfmq_pkg::word_t   rd;
        logic              fnd;
        cfmq_pkg::cnt_t    occ;
    } op_result_t;

    typedef struct packed {
        logic [1:0]        op;
        cfmq_pkg::word_t   data;
        bit                typed;
        cfmq_pkg::status_t st;
        cfmq_pkg::word_t   rd;
        logic              fnd;
        cfmq_pkg::cnt_t    occ;
    } directed_row_t;

    // Run with capacity 2 so that full, wrap and empty all show up quickly.
    localparam int NUM_DIRECTED = 21;
    localparam directed_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
        '{cfmq_pkg::KIND_DEQ,   32'sd0,  1'b1, cfmq_pkg::STATUS_EMPTY, 32'sd0, 1'b0, 5'd0},
        '{cfmq_pkg::KIND_QUERY, 32'sd0,  1'b1, cfmq_pkg::STATUS_OK,    32'sd0, 1'b0, 5'd0},
        '{KIND_UNUSED,          -32'sd1, 1'b1, cfmq_pkg::STATUS_OK,    32'sd0, 1'b0, 5'd0},
        '{cfmq_pkg::KIND_ENQ,   W_MAX,   1'b1, cfmq_pkg::STATUS_OK,    32'sd0, 1'b0, 5'd1},
        '{cfmq_pkg::KIND_ENQ,   W_MIN,   1'b1, cfmq_pkg::STATUS_OK,    32'sd0, 1'b0, 5'd2},
        '{cfmq_pkg::KIND_ENQ,   32'sd0,  1'b1, cfmq_pkg::STATUS_FULL,  32'sd0, 1'b0, 5'd2},
        '{cfmq_pkg::KIND_QUERY, W_MIN,   1'b1, cfmq_pkg::STATUS_OK,    32'sd0, 1'b1, 5'd2},
        '{cfmq_pkg::KIND_QUERY, 32'sd0,  1'b1, cfmq_pkg::STATUS_OK,    32'sd0, 1'b0, 5'd2},
        '{cfmq_pkg::KIND_QUERY, W_MAX,   1'b0, cfmq_pkg::STATUS_OK,    32'sd0, 1'b0, 5'd0},
        '{KIND_UNUSED,          32'sd5,  1'b1, cfmq_pkg::STATUS_OK,    32'sd0, 1'b0, 5'd2},
        '{cfmq_pkg::KIND_DEQ,   32'sd0,  1'b1, cfmq_pkg::STATUS_OK,    W_MAX,  1'b0, 5'd1},
        '{cfmq_pkg::KIND_ENQ,   -32'sd1, 1'b0, cfmq_pkg::STATUS_OK,    32'sd0, 1'b0, 5'd0},
        '{cfmq_pkg::KIND_DEQ,   32'sd0,  1'b0, cfmq_pkg::STATUS_OK,    32'sd0, 1'b0, 5'd0},
        '{cfmq_pkg::KIND_QUERY, -32'sd1, 1'b0, cfmq_pkg::STATUS_OK,    32'sd0, 1'b0, 5'd0},
        '{cfmq_pkg::KIND_DEQ,   32'sd0,  1'b0, cfmq_pkg::STATUS_OK,    32'sd0, 1'b0, 5'd0},
        '{cfmq_pkg::KIND_DEQ,   W_MAX,   1'b1, cfmq_pkg::STATUS_EMPTY, 32'sd0, 1'b0, 5'd0},
        '{cfmq_pkg::KIND_ENQ,   32'sh5555_5555, 1'b0, cfmq_pkg::STATUS_OK, 32'sd0, 1'b0, 5'd0},
        '{cfmq_pkg::KIND_ENQ,   32'shAAAA_AAAA, 1'b0, cfmq_pkg::STATUS_OK, 32'sd0, 1'b0, 5'd0},
        '{cfmq_pkg::KIND_QUERY, 32'shAAAA_AAAA, 1'b0, cfmq_pkg::STATUS_OK, 32'sd0, 1'b0, 5'd0},
        '{cfmq_pkg::KIND_DEQ,   32'sd0,  1'b0, cfmq_pkg::STATUS_OK,    32'sd0, 1'b0, 5'd0},
        '{cfmq_pkg::KIND_DEQ,   32'sd0,  1'b0, cfmq_pkg::STATUS_OK,    32'sd0, 1'b0, 5'd0}
    };

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [1:0]        kind;
    logic signed [31:0] value;
    logic              out_valid;
    logic              out_ready;
    logic [1:0]        status;
    logic signed [31:0] read_value;
    logic              found;
    logic [4:0]        occupancy;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [4:0]        capacity;

    // Shadow of the queue, updated on every accepted transaction.
    cfmq_pkg::word_t ring_mem [cfmq_pkg::DEPTH];
    cfmq_pkg::idx_t  ring_head = '0;
    cfmq_pkg::idx_t  ring_tail = '0;
    cfmq_pkg::cnt_t  ring_count = '0;
    cfmq_pkg::cap_t  ring_cap = 5'd16;

    op_result_t pending_results [$];
    bit         item_typed;
    op_result_t item_typed_res;

    int    error_count = 0;
    int    cycle_count = 0;
    int    burst_left = 0;
    bit    sender_steady = 1'b0;
    cfmq_pkg::word_t val_pool [8];
    int    pool_wr = 0;

    int    rx_mode = 0;
    int    rx_mode_left = 0;
    int    rx_hold = 0;

    circular_fifo_with_membership_query uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .read_value (read_value),
        .found      (found),
        .occupancy  (occupancy),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .capacity   (capacity)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic cfmq_pkg::idx_t wrap_next(input cfmq_pkg::idx_t i, input int ecap);
        int n;
        n = int'(i) + 1;
        return (n >= ecap) ? cfmq_pkg::idx_t'(0) : cfmq_pkg::idx_t'(n);
    endfunction

    function automatic op_result_t apply_fifo_op(input logic [1:0] op,
                                                 input cfmq_pkg::word_t data);
        op_result_t     r;
        int             ecap;
        cfmq_pkg::idx_t idx;
        r = '{st: cfmq_pkg::STATUS_OK, rd: '0, fnd: 1'b0, occ: '0};
        ecap = (ring_cap == '0) ? 1 :
               ((int'(ring_cap) > cfmq_pkg::DEPTH) ? cfmq_pkg::DEPTH : int'(ring_cap));
        case (op)
            cfmq_pkg::KIND_ENQ:
            begin
                if (int'(ring_count) >= ecap)
                begin
                    r.st = cfmq_pkg::STATUS_FULL;
                end
                else
                begin
                    ring_mem[ring_tail] = data;
                    ring_tail = wrap_next(ring_tail, ecap);
                    ring_count = ring_count + cfmq_pkg::cnt_t'(1);
                end
            end
            cfmq_pkg::KIND_DEQ:
            begin
                if (ring_count == '0)
                begin
                    r.st = cfmq_pkg::STATUS_EMPTY;
                end
                else
                begin
                    r.rd = ring_mem[ring_head];
                    ring_head = wrap_next(ring_head, ecap);
                    ring_count = ring_count - cfmq_pkg::cnt_t'(1);
                end
            end
            cfmq_pkg::KIND_QUERY:
            begin
                idx = ring_head;
                for (int i = 0; i < int'(ring_count); i++)
                begin
                    if (ring_mem[idx] == data)
                    begin
                        r.fnd = 1'b1;
                    end
                    idx = wrap_next(idx, ecap);
                end
            end
            default:
            begin
            end
        endcase
        r.occ = ring_count;
        return r;
    endfunction

    task automatic note_mismatch(input string field, input longint want, input longint got);
        error_count++;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
    endtask

    // Check outputs first so a result can never match an item accepted on the same edge.
    always @(posedge clk)
    begin
        op_result_t want;
        op_result_t pred;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    note_mismatch("unexpected result, occupancy", -1, occupancy);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (status !== want.st)
                        note_mismatch("status", want.st, status);
                    if (read_value !== want.rd)
                        note_mismatch("read_value", want.rd, read_value);
                    if (found !== want.fnd)
                        note_mismatch("found", want.fnd, found);
                    if (occupancy !== want.occ)
                        note_mismatch("occupancy", want.occ, occupancy);
                end
            end
            if (in_valid && in_ready)
            begin
                pred = apply_fifo_op(kind, value);
                pending_results.push_back(item_typed ? item_typed_res : pred);
            end
            if (cfg_valid && cfg_ready)
            begin
                ring_cap = capacity;
                ring_head = '0;
                ring_tail = '0;
                ring_count = '0;
            end
        end
    end

    // Receiver: switch between always ready, random stalls and long stalls.
    always @(posedge clk)
    begin
        if (rx_mode_left == 0)
        begin
            rx_mode <= $urandom_range(0, 2);
            rx_mode_left <= $urandom_range(50, 300);
        end
        else
        begin
            rx_mode_left <= rx_mode_left - 1;
        end
        if (rx_hold != 0)
        begin
            rx_hold <= rx_hold - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            case (rx_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 3) != 0);
                default:
                begin
                    if ($urandom_range(0, 7) == 0)
                    begin
                        rx_hold <= $urandom_range(2, 12);
                        out_ready <= 1'b0;
                    end
                    else
                    begin
                        out_ready <= 1'b1;
                    end
                end
            endcase
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_op(input logic [1:0] op, input cfmq_pkg::word_t data,
                           input bit has_typed, input op_result_t typed_res);
        int gap;
        if (!sender_steady)
        begin
            if (burst_left == 0)
            begin
                gap = $urandom_range(1, 8);
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
        end
        in_valid <= 1'b1;
        kind <= op;
        value <= data;
        item_typed <= has_typed;
        item_typed_res <= typed_res;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Wait until every result is back and the block has gone quiet.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
        repeat (IDLE_SETTLE) @(posedge clk);
    endtask

    task automatic set_capacity(input cfmq_pkg::cap_t cap);
        wait_idle();
        cfg_valid <= 1'b1;
        capacity <= cap;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input int n_items);
        int              i;
        int              r;
        int              flip_left;
        bit              filling;
        logic [1:0]      op;
        cfmq_pkg::word_t data;
        flip_left = 0;
        filling = 1'b1;
        for (i = 0; i < n_items; i++)
        begin
            // Alternate fill-heavy and drain-heavy stretches to reach full and empty.
            if (flip_left == 0)
            begin
                filling = ($urandom_range(0, 1) == 1);
                flip_left = $urandom_range(4, 40);
            end
            flip_left--;
            r = $urandom_range(0, 99);
            if (r < 4)
                op = KIND_UNUSED;
            else if (r < 28)
                op = cfmq_pkg::KIND_QUERY;
            else if ($urandom_range(0, 99) < (filling ? 75 : 25))
                op = cfmq_pkg::KIND_ENQ;
            else
                op = cfmq_pkg::KIND_DEQ;
            case ($urandom_range(0, 9))
                0: data = W_MAX;
                1: data = W_MIN;
                2: data = '0;
                3: data = -32'sd1;
                4, 5: data = val_pool[$urandom_range(0, 7)];
                default: data = $urandom;
            endcase
            if (op == cfmq_pkg::KIND_QUERY && $urandom_range(0, 1) == 1)
            begin
                data = val_pool[$urandom_range(0, 7)];
            end
            if (op == cfmq_pkg::KIND_ENQ)
            begin
                val_pool[pool_wr] = data;
                pool_wr = (pool_wr + 1) % 8;
            end
            send_op(op, data, 1'b0, '0);
        end
    endtask

    initial
    begin
        op_result_t     typed_res;
        cfmq_pkg::cap_t phase_caps [NUM_PHASES];
        int             p;
        in_valid <= 1'b0;
        kind <= cfmq_pkg::KIND_ENQ;
        value <= '0;
        out_ready <= 1'b0;
        cfg_valid <= 1'b0;
        capacity <= 5'd16;
        item_typed <= 1'b0;
        item_typed_res <= '0;
        rst_n <= 1'b0;
        foreach (val_pool[k])
        begin
            val_pool[k] = $urandom;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_capacity(5'd2);
        for (p = 0; p < NUM_DIRECTED; p++)
        begin
            typed_res = '{st: DIRECTED_ROWS[p].st, rd: DIRECTED_ROWS[p].rd,
                          fnd: DIRECTED_ROWS[p].fnd, occ: DIRECTED_ROWS[p].occ};
            send_op(DIRECTED_ROWS[p].op, DIRECTED_ROWS[p].data, DIRECTED_ROWS[p].typed,
                    typed_res);
        end

        // Zero acts as one, anything above the depth saturates.
        phase_caps = '{5'd0, 5'd1, 5'd16, 5'd31, 5'd17, 5'd0, 5'd0, 5'd3};
        phase_caps[5] = cfmq_pkg::cap_t'($urandom_range(0, 31));
        phase_caps[6] = cfmq_pkg::cap_t'($urandom_range(0, 31));
        for (p = 0; p < NUM_PHASES; p++)
        begin
            set_capacity(phase_caps[p]);
            sender_steady = (p == 2 || p == 6);
            run_random(PHASE_ITEMS);
        end

        wait_idle();
        if (error_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
